@@ sv/amo_unit_pkg.sv @@
// Shared constants for the atomic memory operation unit.
`default_nettype none

package amo_unit_pkg;

  // Number of 32-bit words in the memory and the width of a word index.
  localparam int MEM_WORDS = 1024;
  localparam int IDX_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // Operation codes carried on the cmd port.
  localparam logic [3:0] CMD_LR   = 4'd0;
  localparam logic [3:0] CMD_SC   = 4'd1;
  localparam logic [3:0] CMD_SWAP = 4'd2;
  localparam logic [3:0] CMD_ADD  = 4'd3;
  localparam logic [3:0] CMD_XOR  = 4'd4;
  localparam logic [3:0] CMD_AND  = 4'd5;
  localparam logic [3:0] CMD_OR   = 4'd6;
  localparam logic [3:0] CMD_MIN  = 4'd7;
  localparam logic [3:0] CMD_MAX  = 4'd8;
  localparam logic [3:0] CMD_MINU = 4'd9;
  localparam logic [3:0] CMD_MAXU = 4'd10;

  // Configuration register space: the register index is paddr[2].
  localparam int          PADDR_W       = 3;
  localparam logic        REG_RAM_BASE  = 1'b0;
  localparam logic [31:0] RAM_BASE_INIT = 32'h8000_0000;

endpackage

`default_nettype wire

@@ sv/atomic_memory_op_unit_core.sv @@
// Top level of the atomic memory operation unit: request decode, word memory and result stage.
`default_nettype none

// Atomic memory unit for RV32A requests. Each word on the input channel names an
// operation, a byte address and an operand; exactly one result word (old memory
// word or zero, plus a fault flag) comes back for each. A request first has its
// address decoded and the read of the single-port word memory issued, then the
// read data combined with the operand and written back once the result stage is
// free, so the unit takes no new word before it is through with the last one.
// The next request is only accepted after the write-back, so back-to-back
// accesses to one word always see the updated value. After reset the unit runs
// a clearing pass that zeroes all MEM_WORDS (1024) memory words, accepting no
// request during it; ram_base can be written at any time over the APB port.
module atomic_memory_op_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  cmd,
  input  wire logic [31:0] address,
  input  wire logic [31:0] operand,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result,
  output logic             fault,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [amo_unit_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IDX_W = amo_unit_pkg::IDX_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_cnt;
  logic [31:0]       ram_base;

  // Request held between decode and execute.
  logic [3:0]        req_cmd;
  logic [31:0]       req_operand;
  logic [IDX_W-1:0]  req_idx;
  logic              req_fault;
  logic              req_access;

  // Memory port signals.
  logic [31:0]       mem [amo_unit_pkg::MEM_WORDS];
  logic [31:0]       mem_rdata;
  logic              mem_re;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [31:0]       mem_wdata;

  logic              in_accept;
  logic              out_free;
  logic              cfg_write;
  logic [31:0]       offset;
  logic              dec_fault;
  logic              dec_cmd_ok;
  logic [31:0]       new_word;
  logic [31:0]       res_word;

  // Combine the old word with the operand for the read-modify-write commands.
  function automatic logic [31:0] combine(input logic [3:0] op_cmd,
                                          input logic [31:0] old,
                                          input logic [31:0] op);
    logic [31:0] val;
    case (op_cmd)
      amo_unit_pkg::CMD_SWAP: val = op;
      amo_unit_pkg::CMD_ADD:  val = old + op;
      amo_unit_pkg::CMD_XOR:  val = old ^ op;
      amo_unit_pkg::CMD_AND:  val = old & op;
      amo_unit_pkg::CMD_OR:   val = old | op;
      amo_unit_pkg::CMD_MIN:  val = ($signed(op) < $signed(old)) ? op : old;
      amo_unit_pkg::CMD_MAX:  val = ($signed(old) < $signed(op)) ? op : old;
      amo_unit_pkg::CMD_MINU: val = (op < old) ? op : old;
      default:                val = (op > old) ? op : old;
    endcase
    return val;
  endfunction

  // Configuration register: always ready, index taken from paddr[2].
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == amo_unit_pkg::REG_RAM_BASE) ? ram_base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base <= amo_unit_pkg::RAM_BASE_INIT;
    end else if (cfg_write && paddr[2] == amo_unit_pkg::REG_RAM_BASE) begin
      ram_base <= pwdata;
    end
  end

  // Handshake conditions.
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Address decode: word offset from the memory base, alignment and range checks.
  assign offset     = address - ram_base;
  assign dec_cmd_ok = (cmd <= amo_unit_pkg::CMD_MAXU);
  assign dec_fault  = (address[1:0] != 2'b00) || (offset[1:0] != 2'b00) ||
                      (offset[31:2] >= 30'(amo_unit_pkg::MEM_WORDS));

  // Write-back value and returned word for the request in execute.
  assign new_word = (req_cmd == amo_unit_pkg::CMD_SC) ? req_operand :
                    combine(req_cmd, mem_rdata, req_operand);
  assign res_word = (req_access && req_cmd != amo_unit_pkg::CMD_SC) ? mem_rdata : 32'd0;

  // Memory port control: clearing pass or write-back of a completed request.
  assign mem_re = in_accept;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_idx;
    mem_wdata = new_word;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = 32'd0;
    end else if (state == ST_EXEC && out_free && req_access &&
                 req_cmd != amo_unit_pkg::CMD_LR) begin
      mem_we = 1'b1;
    end
  end

  // Word memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[offset[IDX_W+1:2]];
    end
  end

  // Sequencer with request and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_EXEC) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(amo_unit_pkg::MEM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_cmd     <= cmd;
      req_operand <= operand;
      req_idx     <= offset[IDX_W+1:2];
      req_fault   <= dec_cmd_ok && dec_fault;
      req_access  <= dec_cmd_ok && !dec_fault;
    end
    if (state == ST_EXEC && out_free) begin
      result <= res_word;
      fault  <= req_fault;
    end
  end

  // No request is taken while the memory is being cleared.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");

  // A faulting request returns zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault) |-> (result == 32'd0))
    else $error("fault with nonzero result");

  // An accepted request blocks the next one until its write-back is done.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (in_stall && state == ST_EXEC))
    else $error("request accepted before write-back");

  // The memory is written only by the clearing pass or by a completing request.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || (state == ST_EXEC && out_free)))
    else $error("memory write outside clear or execute");

endmodule

`default_nettype wire
